// ----- hdl/tmfp_pkg.sv -----
// ----------------------------------------------------------------------------
// tmfp_pkg
// Shared types and constants for the tile-map format parser.
// ----------------------------------------------------------------------------
package tmfp_pkg;

  // Parser phases
  typedef enum logic [3:0] {
    PH_MAGIC    = 4'd0,
    PH_VERSION  = 4'd1,
    PH_TOPO     = 4'd2,
    PH_LAYERS   = 4'd3,
    PH_RESERVED = 4'd4,
    PH_WIDTH    = 4'd5,
    PH_HEIGHT   = 4'd6,
    PH_NAMELEN  = 4'd7,
    PH_NAMECHAR = 4'd8,
    PH_TILE     = 4'd9,
    PH_ELEV     = 4'd10,
    PH_FLAGS    = 4'd11,
    PH_DONE     = 4'd12
  } phase_e;

  // Record kinds
  typedef enum logic [2:0] {
    K_HEADER    = 3'd0,
    K_NAME_LEN  = 3'd1,
    K_NAME_CHAR = 3'd2,
    K_TILE      = 3'd3,
    K_ELEV      = 3'd4,
    K_FLAGS     = 3'd5,
    K_ACCEPT    = 3'd6,
    K_REJECT    = 3'd7
  } kind_e;

  // Reject codes
  typedef enum logic [2:0] {
    E_MAGIC     = 3'd0,
    E_VERSION   = 3'd1,
    E_TOPOLOGY  = 3'd2,
    E_NO_LAYERS = 3'd3,
    E_SIZE      = 3'd4,
    E_TRUNCATED = 3'd5,
    E_TRAILING  = 3'd6
  } err_e;

  localparam logic [7:0] MagicB = 8'h42;
  localparam logic [7:0] MagicT = 8'h54;
  localparam logic [7:0] MagicI = 8'h49;
  localparam logic [7:0] MagicL = 8'h4C;
  localparam logic [7:0] FormatVersion = 8'd1;

  // Output queue depth (two entries per byte must always fit)
  localparam int unsigned OutDepth = 4;

  // One result word
  typedef struct packed {
    kind_e        kind;
    logic [31:0]  value;
    logic [7:0]   layer_index;
    logic [61:0]  position;
    logic         topology;
    logic [7:0]   layers_total;
    logic [30:0]  grid_width;
    logic [30:0]  grid_height;
    err_e         error_code;
    logic         last;
  } rec_t;

  // Push request from the parser core to the output queue
  typedef struct packed {
    logic [1:0] cnt;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = MagicB;
      2'd1:    r = MagicT;
      2'd2:    r = MagicI;
      default: r = MagicL;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/tile_map_format_parser_unit.sv -----
// ----------------------------------------------------------------------------
// tile_map_format_parser_unit
// Tile-map byte stream parser with field records and accept/reject verdict.
// ----------------------------------------------------------------------------
// Input channel: one stream byte per word (data_byte_i, end_of_stream_i on
// the final byte), valid/ready. Output channel: one record per word,
// valid/ready, with last_o on the final record caused by a byte.
// A byte is parsed in the cycle it is taken; its records (none, one or two)
// sit in a four-word queue and show on the output from the next cycle.
// Throughput is one byte per cycle while the queue has room; a byte giving
// two records adds two queue words, so input ready drops while the queue
// holds more than two.
// Output stalls back-pressure the input only through that queue fill level.
// Reset empties the queue and puts the parser at the magic of a new stream;
// after each end byte the parser restarts by itself.
// ----------------------------------------------------------------------------
module tile_map_format_parser_unit #(
  parameter int unsigned QueueDepth = tmfp_pkg::OutDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [31:0] value_o,
  output logic [7:0]  layer_index_o,
  output logic [61:0] position_o,
  output logic        topology_o,
  output logic [7:0]  layers_total_o,
  output logic [30:0] grid_width_o,
  output logic [30:0] grid_height_o,
  output logic [2:0]  error_code_o,
  output logic        last_o
);

  tmfp_pkg::push_t push;
  tmfp_pkg::rec_t  head;
  logic            room;
  logic            accept;

  assign in_ready_o = room;
  assign accept     = in_valid_i && room;

  tmfp_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .push_o          (push)
  );

  tmfp_outq #(.Depth(QueueDepth)) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  // Unpack head word
  assign kind_o         = head.kind;
  assign value_o        = head.value;
  assign layer_index_o  = head.layer_index;
  assign position_o     = head.position;
  assign topology_o     = head.topology;
  assign layers_total_o = head.layers_total;
  assign grid_width_o   = head.grid_width;
  assign grid_height_o  = head.grid_height;
  assign error_code_o   = head.error_code;
  assign last_o         = head.last;

endmodule

// ----- hdl/tmfp_core.sv -----
// ----------------------------------------------------------------------------
// tmfp_core
// Parser state and one-byte step logic; emits up to two result words.
// ----------------------------------------------------------------------------
module tmfp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_stream_i,
  output tmfp_pkg::push_t   push_o
);

  tmfp_pkg::phase_e phase_q, phase_d;
  logic [2:0]  fbc_q, fbc_d;
  logic [31:0] shift_q, shift_d;
  logic        topo_q, topo_d;
  logic [7:0]  lcs_q, lcs_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic [61:0] cell_total_q;
  logic [7:0]  lc_q, lc_d;
  logic [61:0] cc_q, cc_d;
  logic [15:0] nrem_q, nrem_d;
  logic [15:0] npos_q, npos_d;
  logic        drain_q, drain_d;

  logic [31:0] shift_new;
  logic [2:0]  fbc_inc;
  logic [61:0] cc_inc;
  logic [7:0]  lc_inc;
  logic        err_v, fld_v, term_v, reset_all;
  tmfp_pkg::err_e err_c;
  tmfp_pkg::rec_t fld_rec, term_rec;

  // Step logic
  always_comb begin
    phase_d   = phase_q;
    fbc_d     = fbc_q;
    shift_d   = shift_q;
    topo_d    = topo_q;
    lcs_d     = lcs_q;
    width_d   = width_q;
    height_d  = height_q;
    lc_d      = lc_q;
    cc_d      = cc_q;
    nrem_d    = nrem_q;
    npos_d    = npos_q;
    drain_d   = drain_q;
    err_v     = 1'b0;
    err_c     = tmfp_pkg::E_MAGIC;
    fld_v     = 1'b0;
    term_v    = 1'b0;
    reset_all = 1'b0;
    fld_rec   = '0;
    term_rec  = '0;
    shift_new = shift_q | ({24'd0, data_byte_i} << {fbc_q[1:0], 3'b000});
    fbc_inc   = fbc_q + 3'd1;
    cc_inc    = cc_q + 62'd1;
    lc_inc    = lc_q + 8'd1;

    if (drain_q) begin
      reset_all = end_of_stream_i;
    end else begin
      unique case (phase_q)
        tmfp_pkg::PH_MAGIC: begin
          if (data_byte_i != tmfp_pkg::magic_byte(fbc_q[1:0])) begin
            err_v = 1'b1;
            err_c = tmfp_pkg::E_MAGIC;
          end else if (fbc_inc >= 3'd4) begin
            fbc_d   = '0;
            phase_d = tmfp_pkg::PH_VERSION;
          end else begin
            fbc_d = fbc_inc;
          end
        end
        tmfp_pkg::PH_VERSION: begin
          if (data_byte_i != tmfp_pkg::FormatVersion) begin
            err_v = 1'b1;
            err_c = tmfp_pkg::E_VERSION;
          end else begin
            phase_d = tmfp_pkg::PH_TOPO;
          end
        end
        tmfp_pkg::PH_TOPO: begin
          if (data_byte_i > 8'd1) begin
            err_v = 1'b1;
            err_c = tmfp_pkg::E_TOPOLOGY;
          end else begin
            topo_d  = data_byte_i[0];
            phase_d = tmfp_pkg::PH_LAYERS;
          end
        end
        tmfp_pkg::PH_LAYERS: begin
          if (data_byte_i == 8'd0) begin
            err_v = 1'b1;
            err_c = tmfp_pkg::E_NO_LAYERS;
          end else begin
            lcs_d   = data_byte_i;
            phase_d = tmfp_pkg::PH_RESERVED;
          end
        end
        tmfp_pkg::PH_RESERVED: phase_d = tmfp_pkg::PH_WIDTH;
        tmfp_pkg::PH_WIDTH, tmfp_pkg::PH_HEIGHT: begin
          if (fbc_inc >= 3'd4) begin
            shift_d = '0;
            fbc_d   = '0;
            if (shift_new == 32'd0 || shift_new[31]) begin
              err_v = 1'b1;
              err_c = tmfp_pkg::E_SIZE;
            end else if (phase_q == tmfp_pkg::PH_WIDTH) begin
              width_d = shift_new;
              phase_d = tmfp_pkg::PH_HEIGHT;
            end else begin
              height_d             = shift_new;
              fld_v                = 1'b1;
              fld_rec.kind         = tmfp_pkg::K_HEADER;
              fld_rec.topology     = topo_q;
              fld_rec.layers_total = lcs_q;
              fld_rec.grid_width   = width_q[30:0];
              fld_rec.grid_height  = shift_new[30:0];
              lc_d                 = '0;
              phase_d              = tmfp_pkg::PH_NAMELEN;
            end
          end else begin
            shift_d = shift_new;
            fbc_d   = fbc_inc;
          end
        end
        tmfp_pkg::PH_NAMELEN: begin
          if (fbc_inc >= 3'd2) begin
            shift_d             = '0;
            fbc_d               = '0;
            fld_v               = 1'b1;
            fld_rec.kind        = tmfp_pkg::K_NAME_LEN;
            fld_rec.value       = {16'd0, shift_new[15:0]};
            fld_rec.layer_index = lc_q;
            nrem_d              = shift_new[15:0];
            npos_d              = '0;
            if (shift_new[15:0] == 16'd0) begin
              if (lc_inc == lcs_q) begin
                lc_d    = '0;
                cc_d    = '0;
                phase_d = tmfp_pkg::PH_TILE;
              end else begin
                lc_d    = lc_inc;
                phase_d = tmfp_pkg::PH_NAMELEN;
              end
            end else begin
              phase_d = tmfp_pkg::PH_NAMECHAR;
            end
          end else begin
            shift_d = shift_new;
            fbc_d   = fbc_inc;
          end
        end
        tmfp_pkg::PH_NAMECHAR: begin
          fld_v               = 1'b1;
          fld_rec.kind        = tmfp_pkg::K_NAME_CHAR;
          fld_rec.value       = {24'd0, data_byte_i};
          fld_rec.layer_index = lc_q;
          fld_rec.position    = {46'd0, npos_q};
          npos_d              = npos_q + 16'd1;
          nrem_d              = nrem_q - 16'd1;
          if (nrem_q == 16'd1) begin
            if (lc_inc == lcs_q) begin
              lc_d    = '0;
              cc_d    = '0;
              phase_d = tmfp_pkg::PH_TILE;
            end else begin
              lc_d    = lc_inc;
              phase_d = tmfp_pkg::PH_NAMELEN;
            end
          end
        end
        tmfp_pkg::PH_TILE, tmfp_pkg::PH_ELEV, tmfp_pkg::PH_FLAGS: begin
          if (fbc_inc >= ((phase_q == tmfp_pkg::PH_FLAGS) ? 3'd4 : 3'd2)) begin
            shift_d          = '0;
            fbc_d            = '0;
            fld_v            = 1'b1;
            fld_rec.value    = shift_new;
            fld_rec.position = cc_q;
            if (phase_q == tmfp_pkg::PH_TILE) begin
              fld_rec.kind        = tmfp_pkg::K_TILE;
              fld_rec.layer_index = lc_q;
            end else if (phase_q == tmfp_pkg::PH_ELEV) begin
              fld_rec.kind = tmfp_pkg::K_ELEV;
            end else begin
              fld_rec.kind = tmfp_pkg::K_FLAGS;
            end
            cc_d = cc_inc;
            if (cc_inc >= cell_total_q) begin
              cc_d = '0;
              if (phase_q == tmfp_pkg::PH_TILE) begin
                lc_d = lc_inc;
                if (lc_inc >= lcs_q) begin
                  lc_d    = '0;
                  phase_d = tmfp_pkg::PH_ELEV;
                end
              end else if (phase_q == tmfp_pkg::PH_ELEV) begin
                phase_d = tmfp_pkg::PH_FLAGS;
              end else begin
                phase_d = tmfp_pkg::PH_DONE;
              end
            end
          end else begin
            shift_d = shift_new;
            fbc_d   = fbc_inc;
          end
        end
        default: begin
          err_v = 1'b1;
          err_c = tmfp_pkg::E_TRAILING;
        end
      endcase

      // Terminal word
      if (err_v) begin
        term_v              = 1'b1;
        term_rec.kind       = tmfp_pkg::K_REJECT;
        term_rec.error_code = err_c;
        if (end_of_stream_i) reset_all = 1'b1;
        else drain_d = 1'b1;
      end else if (end_of_stream_i) begin
        term_v    = 1'b1;
        reset_all = 1'b1;
        if (phase_d == tmfp_pkg::PH_DONE) begin
          term_rec.kind = tmfp_pkg::K_ACCEPT;
        end else begin
          term_rec.kind       = tmfp_pkg::K_REJECT;
          term_rec.error_code = tmfp_pkg::E_TRUNCATED;
        end
      end
    end

    if (reset_all) begin
      phase_d  = tmfp_pkg::PH_MAGIC;
      fbc_d    = '0;
      shift_d  = '0;
      topo_d   = 1'b0;
      lcs_d    = '0;
      width_d  = '0;
      height_d = '0;
      lc_d     = '0;
      cc_d     = '0;
      nrem_d   = '0;
      npos_d   = '0;
      drain_d  = 1'b0;
    end

    if (term_v) term_rec.last = 1'b1;
    else fld_rec.last = 1'b1;
  end

  // Push request: field word first, terminal word second
  always_comb begin
    push_o.rec0 = fld_v ? fld_rec : term_rec;
    push_o.rec1 = term_rec;
    push_o.cnt  = accept_i ? ({1'b0, fld_v} + {1'b0, term_v}) : 2'd0;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= tmfp_pkg::PH_MAGIC;
      fbc_q    <= '0;
      shift_q  <= '0;
      topo_q   <= 1'b0;
      lcs_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      lc_q     <= '0;
      cc_q     <= '0;
      nrem_q   <= '0;
      npos_q   <= '0;
      drain_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      fbc_q    <= fbc_d;
      shift_q  <= shift_d;
      topo_q   <= topo_d;
      lcs_q    <= lcs_d;
      width_q  <= width_d;
      height_q <= height_d;
      lc_q     <= lc_d;
      cc_q     <= cc_d;
      nrem_q   <= nrem_d;
      npos_q   <= npos_d;
      drain_q  <= drain_d;
    end
  end

  // Plane size; ready well before the first tile byte arrives
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_total_q <= '0;
    end else begin
      cell_total_q <= {31'd0, width_q[30:0]} * {31'd0, height_q[30:0]};
    end
  end

endmodule

// ----- hdl/tmfp_outq.sv -----
// ----------------------------------------------------------------------------
// tmfp_outq
// Small result queue; takes up to two words per cycle, gives one.
// ----------------------------------------------------------------------------
module tmfp_outq #(
  parameter int unsigned Depth = tmfp_pkg::OutDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tmfp_pkg::push_t  push_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tmfp_pkg::rec_t   head_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  tmfp_pkg::rec_t mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q, wr_p1;
  logic [CW-1:0] cnt_q;
  logic          pop;

  assign wr_p1       = wr_q + AW'(1);
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign room_o      = (cnt_q <= CW'(Depth - 2));
  assign head_o      = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_q] <= push_i.rec0;
    if (push_i.cnt == 2'd2) mem_q[wr_p1] <= push_i.rec1;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + AW'(push_i.cnt);
      if (pop) rd_q <= rd_q + AW'(1);
      cnt_q <= cnt_q + CW'(push_i.cnt) - CW'(pop);
    end
  end

  // Checks
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Depth)) else $error("result queue overfilled");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> room_o) else $error("push without room");
  a_pop_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.cnt == 2'd0) |=> (cnt_q == $past(cnt_q) - CW'(1)))
    else $error("fill level lost a pop");

endmodule
